FILE: design/hslrgb_pkg.sv
// Shared types for the HSL to RGB converter pipeline.
`default_nettype none

package hslrgb_pkg;

    // Width of every pixel field on the ports.
    localparam int FIELD_W = 12;

    // Hue offsets of the three channels, in units of one sixth of a turn.
    localparam int HUE_OFS_RED   = 2;
    localparam int HUE_OFS_GREEN = 0;
    localparam int HUE_OFS_BLUE  = 4;

    // Segment of the piecewise-linear hue ramp.
    typedef enum logic [1:0] {
        RAMP_SLOPE,
        RAMP_HIGH,
        RAMP_LOW
    } t_ramp_mode;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_pipe_ctl;

endpackage

`default_nettype wire

FILE: design/hsl_to_rgb_converter_core.sv
// Top level of the HSL to RGB converter: stage control and channel instances.
`default_nettype none

// Converts one HSL pixel (unsigned Q0.12 fractions, hue wrapping modulo one turn)
// into one RGB pixel whose channels saturate to 0..4095. The pipeline has four
// register stages: product of lightness and saturation with the hue offsets,
// then q, p and the ramp segment, then the three slope products, then the
// output register. A request is taken every clock cycle unless o_stall is high;
// each stage holds while the one after it is full and stalled, so bubbles close
// up and the input side stalls only when all four stages are full and the
// output is stalled. Zero saturation gives grey at the lightness level.
module hsl_to_rgb_converter_core #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [hslrgb_pkg::FIELD_W-1:0]   i_hue,
    input  wire logic [hslrgb_pkg::FIELD_W-1:0]   i_saturation,
    input  wire logic [hslrgb_pkg::FIELD_W-1:0]   i_lightness,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic      [hslrgb_pkg::FIELD_W-1:0]   o_red,
    output logic      [hslrgb_pkg::FIELD_W-1:0]   o_green,
    output logic      [hslrgb_pkg::FIELD_W-1:0]   o_blue
);

    localparam int F = FRAC_BITS;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    hslrgb_pkg::t_pipe_ctl ctl;

    logic [F-1:0] hue_m;
    logic [F-1:0] sat_m;
    logic [F-1:0] lig_m;

    logic [F:0]   span;
    logic [F-1:0] p;
    logic [F:0]   q;
    logic [F-1:0] lig3;
    logic         grey;

    assign hue_m = F'(i_hue);
    assign sat_m = F'(i_saturation);
    assign lig_m = F'(i_lightness);

    // A stage loads when it is empty or the stage after it moves on.
    assign ld4 = !r_v4 || !i_stall;
    assign ld3 = !r_v3 || ld4;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;
    assign ctl = {ld1, ld2, ld3, ld4};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= i_valid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
            if (ld4) begin
                r_v4 <= r_v3;
            end
        end
    end

    assign o_stall = !ld1;
    assign o_valid = r_v4;

    hslrgb_span #(
        .FRAC_BITS (FRAC_BITS)
    ) u_span (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_saturation (sat_m),
        .i_lightness  (lig_m),
        .o_span       (span),
        .o_p          (p),
        .o_q          (q),
        .o_lightness  (lig3),
        .o_grey       (grey)
    );

    hslrgb_chan #(
        .FRAC_BITS (FRAC_BITS),
        .HUE_OFS   (hslrgb_pkg::HUE_OFS_RED)
    ) u_chan_red (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_hue       (hue_m),
        .i_span      (span),
        .i_p         (p),
        .i_q         (q),
        .i_lightness (lig3),
        .i_grey      (grey),
        .o_channel   (o_red)
    );

    hslrgb_chan #(
        .FRAC_BITS (FRAC_BITS),
        .HUE_OFS   (hslrgb_pkg::HUE_OFS_GREEN)
    ) u_chan_green (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_hue       (hue_m),
        .i_span      (span),
        .i_p         (p),
        .i_q         (q),
        .i_lightness (lig3),
        .i_grey      (grey),
        .o_channel   (o_green)
    );

    hslrgb_chan #(
        .FRAC_BITS (FRAC_BITS),
        .HUE_OFS   (hslrgb_pkg::HUE_OFS_BLUE)
    ) u_chan_blue (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_hue       (hue_m),
        .i_span      (span),
        .i_p         (p),
        .i_q         (q),
        .i_lightness (lig3),
        .i_grey      (grey),
        .o_channel   (o_blue)
    );

endmodule

`default_nettype wire

FILE: design/hslrgb_span.sv
// Stages one to three of the shared path: lightness times saturation, q, p and span.
`default_nettype none

module hslrgb_span #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire hslrgb_pkg::t_pipe_ctl  i_ctl,
    input  wire logic [FRAC_BITS-1:0]   i_saturation,
    input  wire logic [FRAC_BITS-1:0]   i_lightness,
    output logic      [FRAC_BITS:0]     o_span,
    output logic      [FRAC_BITS-1:0]   o_p,
    output logic      [FRAC_BITS:0]     o_q,
    output logic      [FRAC_BITS-1:0]   o_lightness,
    output logic                        o_grey
);

    localparam int F = FRAC_BITS;
    localparam logic [2*F-1:0] PROD_HALF = (2*F)'(1) << (F - 1);

    // Stage one.
    logic [2*F-1:0] r_prod;
    logic [F-1:0]   r_s1;
    logic [F-1:0]   r_l1;
    logic           r_grey1;

    // Stage two.
    logic [F:0]     r_span2;
    logic [F-1:0]   r_p2;
    logic [F:0]     r_q2;
    logic [F-1:0]   r_l2;
    logic           r_grey2;

    // Stage three.
    logic [F-1:0]   r_p3;
    logic [F:0]     r_q3;
    logic [F-1:0]   r_l3;
    logic           r_grey3;

    logic [2*F-1:0] prod_rnd;
    logic [F-1:0]   ls;
    logic [F-1:0]   d_raw;
    logic [F-1:0]   d;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_prod  <= (2*F)'(i_lightness) * (2*F)'(i_saturation);
            r_s1    <= i_saturation;
            r_l1    <= i_lightness;
            r_grey1 <= (i_saturation == '0);
        end
    end

    always_comb begin
        prod_rnd = r_prod + PROD_HALF;
        ls       = prod_rnd[2*F-1:F];
        // Below half lightness d is l*s, above it d is s - l*s, floored at zero; d is then capped at l.
        if (!r_l1[F-1]) begin
            d_raw = ls;
        end else if (ls < r_s1) begin
            d_raw = r_s1 - ls;
        end else begin
            d_raw = '0;
        end
        d = (d_raw > r_l1) ? r_l1 : d_raw;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_span2 <= {d, 1'b0};
            r_p2    <= r_l1 - d;
            r_q2    <= {1'b0, r_l1} + {1'b0, d};
            r_l2    <= r_l1;
            r_grey2 <= r_grey1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_p3    <= r_p2;
            r_q3    <= r_q2;
            r_l3    <= r_l2;
            r_grey3 <= r_grey2;
        end
    end

    assign o_span      = r_span2;
    assign o_p         = r_p3;
    assign o_q         = r_q3;
    assign o_lightness = r_l3;
    assign o_grey      = r_grey3;

endmodule

`default_nettype wire

FILE: design/hslrgb_chan.sv
// One color channel: hue offset, ramp segment, slope product and saturated output register.
`default_nettype none

module hslrgb_chan #(
    parameter int FRAC_BITS = 12,
    parameter int HUE_OFS   = 0
) (
    input  wire logic                              i_clk,
    input  wire hslrgb_pkg::t_pipe_ctl             i_ctl,
    input  wire logic [FRAC_BITS-1:0]              i_hue,
    input  wire logic [FRAC_BITS:0]                i_span,
    input  wire logic [FRAC_BITS-1:0]              i_p,
    input  wire logic [FRAC_BITS:0]                i_q,
    input  wire logic [FRAC_BITS-1:0]              i_lightness,
    input  wire logic                              i_grey,
    output logic      [hslrgb_pkg::FIELD_W-1:0]    o_channel
);

    localparam int F = FRAC_BITS;
    localparam logic [F+3:0]   OFS_FULL  = (F+4)'(HUE_OFS) << F;
    localparam logic [F+3:0]   TURN      = (F+4)'(6) << F;
    localparam logic [F+2:0]   ONE_H     = (F+3)'(1) << F;
    localparam logic [F+2:0]   THREE_H   = (F+3)'(3) << F;
    localparam logic [F+2:0]   FOUR_H    = (F+3)'(4) << F;
    localparam logic [2*F+1:0] PROD_HALF = (2*F+2)'(1) << (F - 1);

    logic [F+2:0]   r_h6;
    hslrgb_pkg::t_ramp_mode r_mode2;
    hslrgb_pkg::t_ramp_mode r_mode3;
    logic [F:0]     r_x;
    logic [2*F+1:0] r_prod;
    logic [hslrgb_pkg::FIELD_W-1:0] r_out;

    logic [F+3:0]   h6_sum;
    logic [F+3:0]   h6_wrap;
    hslrgb_pkg::t_ramp_mode mode;
    logic [F+2:0]   x_full;
    logic [2*F+1:0] prod_rnd;
    logic [F+1:0]   v;
    logic [F-1:0]   v_sat;

    // Six times the hue plus the channel offset, wrapped into one turn.
    always_comb begin
        h6_sum  = ((F+4)'(i_hue) << 2) + ((F+4)'(i_hue) << 1) + OFS_FULL;
        h6_wrap = (h6_sum >= TURN) ? (h6_sum - TURN) : h6_sum;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_h6 <= h6_wrap[F+2:0];
        end
    end

    always_comb begin
        x_full = r_h6;
        if (r_h6 < ONE_H) begin
            mode = hslrgb_pkg::RAMP_SLOPE;
        end else if (r_h6 < THREE_H) begin
            mode = hslrgb_pkg::RAMP_HIGH;
        end else if (r_h6 < FOUR_H) begin
            mode   = hslrgb_pkg::RAMP_SLOPE;
            x_full = FOUR_H - r_h6;
        end else begin
            mode = hslrgb_pkg::RAMP_LOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_mode2 <= mode;
            r_x     <= x_full[F:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_mode3 <= r_mode2;
            r_prod  <= (2*F+2)'(i_span) * (2*F+2)'(r_x);
        end
    end

    always_comb begin
        prod_rnd = r_prod + PROD_HALF;
        case (r_mode3)
            hslrgb_pkg::RAMP_SLOPE: v = (F+2)'(i_p) + prod_rnd[2*F+1:F];
            hslrgb_pkg::RAMP_HIGH:  v = (F+2)'(i_q);
            hslrgb_pkg::RAMP_LOW:   v = (F+2)'(i_p);
            default:                v = (F+2)'(i_p);
        endcase
        if (i_grey) begin
            v_sat = i_lightness;
        end else if (v[F+1:F] != 2'b00) begin
            v_sat = '1;
        end else begin
            v_sat = v[F-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld4) begin
            r_out <= hslrgb_pkg::FIELD_W'(v_sat);
        end
    end

    assign o_channel = r_out;

endmodule

`default_nettype wire
